FILE: rtl/lsbe_pkg.sv
// ----------------------------------------------------------------------------
// lsbe_pkg
// Shared types, line-bit patterns and expansion functions for the LED strip
// SPI bit expander.
// ----------------------------------------------------------------------------
package lsbe_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned WordW   = 16;
  localparam int unsigned Exp3W   = 3 * ByteW;
  localparam int unsigned Exp4W   = 4 * ByteW;

  // line-bit patterns for one data bit
  localparam logic [2:0] Pat3One  = 3'b110;
  localparam logic [2:0] Pat3Zero = 3'b100;
  localparam logic [3:0] Pat4One  = 4'b1100;
  localparam logic [3:0] Pat4Zero = 4'b1000;

  // words produced by one byte, handed from the packer to the output buffer
  typedef struct packed {
    logic [WordW-1:0] word0;
    logic [WordW-1:0] word1;
    logic             two;   // word1 is valid
    logic             last;  // final word of the item closes the frame
  } word_pair_t;

  // 3 line bits per data bit, msb first
  function automatic logic [Exp3W-1:0] expand3(input logic [ByteW-1:0] b);
    logic [Exp3W-1:0] e;
    e = '0;
    for (int i = 0; i < ByteW; i++) begin
      e[3*i +: 3] = b[i] ? Pat3One : Pat3Zero;
    end
    return e;
  endfunction

  // 4 line bits per data bit, msb first
  function automatic logic [Exp4W-1:0] expand4(input logic [ByteW-1:0] b);
    logic [Exp4W-1:0] e;
    e = '0;
    for (int i = 0; i < ByteW; i++) begin
      e[4*i +: 4] = b[i] ? Pat4One : Pat4Zero;
    end
    return e;
  endfunction

endpackage

FILE: rtl/led_strip_spi_bit_expander_unit.sv
// ----------------------------------------------------------------------------
// led_strip_spi_bit_expander_unit
// Expands colour bytes into WS2812-style line bits packed in 16-bit SPI words.
// ----------------------------------------------------------------------------
// Each byte enters an input register and is then expanded and packed into
// one or two 16-bit words that land in a two-word result register; words
// leave one per cycle while the receiver does not stall, first line bit in
// bit 15. The single result port takes the next byte as the last word held
// there leaves, so a byte that yields two words (4-bit mode, every second
// byte in 3-bit mode, frame ends) holds the following byte back while its
// first word is sent; in 3-bit mode a byte that yields one word holds none.
// The final word of a frame carries last_word_o. Write the mode only while
// idle; any mode write discards held bits and starts a new frame.
module led_strip_spi_bit_expander_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_four_bit_mode_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [lsbe_pkg::ByteW-1:0] data_byte_i,
  input  logic                       last_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [lsbe_pkg::WordW-1:0] line_word_o,
  output logic                       last_word_o
);

  logic                       full, load_ok, fire, last;
  logic [lsbe_pkg::ByteW-1:0] byte_val;
  lsbe_pkg::word_pair_t       pair;

  // held item moves into the result register when it has room
  assign fire = full && load_ok;

  lsbe_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .take_i      (fire),
    .full_o      (full),
    .byte_o      (byte_val),
    .last_o      (last)
  );

  lsbe_packer u_packer (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_four_bit_mode_i (cfg_four_bit_mode_i),
    .fire_i              (fire),
    .byte_i              (byte_val),
    .last_i              (last),
    .pair_o              (pair)
  );

  lsbe_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_req_i  (full),
    .pair_i      (pair),
    .load_ok_o   (load_ok),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .line_word_o (line_word_o),
    .last_word_o (last_word_o)
  );

endmodule

FILE: rtl/lsbe_in_reg.sv
// ----------------------------------------------------------------------------
// lsbe_in_reg
// Input register: holds one accepted item until the packer takes it.
// ----------------------------------------------------------------------------
module lsbe_in_reg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [lsbe_pkg::ByteW-1:0] data_byte_i,
  input  logic                      last_byte_i,
  input  logic                      take_i,
  output logic                      full_o,
  output logic [lsbe_pkg::ByteW-1:0] byte_o,
  output logic                      last_o
);

  logic                       full_q, full_d;
  logic [lsbe_pkg::ByteW-1:0] byte_q;
  logic                       last_q;
  logic                       accept;

  // room when empty or when the held item moves on this cycle
  assign in_stall_o = full_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    full_d = full_q;
    if (accept) begin
      full_d = 1'b1;
    end else if (take_i) begin
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else begin
      full_q <= full_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  assign full_o = full_q;
  assign byte_o = byte_q;
  assign last_o = last_q;

endmodule

FILE: rtl/lsbe_packer.sv
// ----------------------------------------------------------------------------
// lsbe_packer
// Mode register, held leftover bits and the byte-to-word packing logic.
// ----------------------------------------------------------------------------
module lsbe_packer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_four_bit_mode_i,
  input  logic                       fire_i,
  input  logic [lsbe_pkg::ByteW-1:0] byte_i,
  input  logic                       last_i,
  output lsbe_pkg::word_pair_t       pair_o
);

  logic                       mode_q, mode_d;
  logic                       pend_v_q, pend_v_d;
  logic [lsbe_pkg::ByteW-1:0] pend_q;
  logic [lsbe_pkg::Exp3W-1:0] e3;
  logic [lsbe_pkg::Exp4W-1:0] e4;

  assign e3 = lsbe_pkg::expand3(byte_i);
  assign e4 = lsbe_pkg::expand4(byte_i);

  // word assembly: held bits exist only in 3-bit mode and are always 8 wide
  always_comb begin
    pair_o.last = last_i;
    if (mode_q) begin
      pair_o.word0 = e4[31:16];
      pair_o.word1 = e4[15:0];
      pair_o.two   = 1'b1;
    end else if (pend_v_q) begin
      pair_o.word0 = {pend_q, e3[23:16]};
      pair_o.word1 = e3[15:0];
      pair_o.two   = 1'b1;
    end else begin
      pair_o.word0 = e3[23:8];
      pair_o.word1 = {e3[7:0], {lsbe_pkg::ByteW{1'b0}}};
      pair_o.two   = last_i;
    end
  end

  // state update; a mode write starts a fresh frame
  always_comb begin
    mode_d   = mode_q;
    pend_v_d = pend_v_q;
    if (cfg_we_i) begin
      mode_d   = cfg_four_bit_mode_i;
      pend_v_d = 1'b0;
    end else if (fire_i) begin
      pend_v_d = !mode_q && !pend_v_q && !last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      pend_v_q <= 1'b0;
    end else begin
      mode_q   <= mode_d;
      pend_v_q <= pend_v_d;
    end
  end

  // leftover byte of line bits
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      pend_q <= e3[7:0];
    end
  end

endmodule

FILE: rtl/lsbe_out_buf.sv
// ----------------------------------------------------------------------------
// lsbe_out_buf
// Result register for up to two words, drained one word per output handshake.
// ----------------------------------------------------------------------------
module lsbe_out_buf (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       load_req_i,
  input  lsbe_pkg::word_pair_t       pair_i,
  output logic                       load_ok_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [lsbe_pkg::WordW-1:0] line_word_o,
  output logic                       last_word_o
);

  logic [1:0]                 cnt_q, cnt_d;
  logic [lsbe_pkg::WordW-1:0] w0_q, w1_q;
  logic                       last_q;
  logic                       pop, load;

  assign pop       = (cnt_q != 2'd0) && !out_stall_i;
  assign load_ok_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && !out_stall_i);
  assign load      = load_req_i && load_ok_o;

  // word count
  always_comb begin
    cnt_d = cnt_q;
    if (load) begin
      cnt_d = pair_i.two ? 2'd2 : 2'd1;
    end else if (pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // word slots; second word moves up after the first is taken
  always_ff @(posedge clk_i) begin
    if (load) begin
      w0_q   <= pair_i.word0;
      w1_q   <= pair_i.word1;
      last_q <= pair_i.last;
    end else if (pop) begin
      w0_q <= w1_q;
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign line_word_o = w0_q;
  assign last_word_o = last_q && (cnt_q == 2'd1);

endmodule

FILE: verif/led_strip_spi_bit_expander_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_strip_spi_bit_expander_unit_tb
// Drives colour bytes in 3-bit and 4-bit mode, in frames of random length,
// with random gaps and output stalls. A line-word tracker expands every
// accepted item on its own and checks each 16-bit word and its frame flag
// in order.
// ----------------------------------------------------------------------------
module led_strip_spi_bit_expander_unit_tb;

  localparam int unsigned StuckLimit = 1000;
  localparam int unsigned RandomBytes = 1035;

  // expected line words, in the order the block must send them
  class line_word_tracker;
    typedef struct packed {
      logic [lsbe_pkg::WordW-1:0] word;
      logic                       last;
    } line_word_t;

    line_word_t  words_due[$];
    bit          four_mode;
    logic [15:0] held_bits;
    int unsigned held_count;
    int unsigned errors;
    int unsigned bytes_seen;
    int unsigned frames_closed;
    int unsigned words_checked;

    // any mode write starts a fresh frame
    function void set_mode(bit m);
      four_mode  = m;
      held_bits  = '0;
      held_count = 0;
    endfunction

    // expand one accepted item and queue the words it yields
    function void note_byte(logic [7:0] data, logic last);
      logic [63:0] line_bits;
      logic [63:0] acc;
      int unsigned n;
      int unsigned cnt;
      line_word_t  w;
      line_bits = '0;
      for (int i = 7; i >= 0; i--) begin
        if (four_mode) begin
          line_bits = (line_bits << 4) | (data[i] ? lsbe_pkg::Pat4One : lsbe_pkg::Pat4Zero);
        end else begin
          line_bits = (line_bits << 3) | (data[i] ? lsbe_pkg::Pat3One : lsbe_pkg::Pat3Zero);
        end
      end
      n   = four_mode ? 32 : 24;
      acc = ({48'd0, held_bits} << n) | line_bits;
      cnt = held_count + n;
      bytes_seen++;
      // full words, oldest bits first
      while (cnt >= 16) begin
        cnt -= 16;
        w.word = 16'(acc >> cnt);
        w.last = 1'b0;
        words_due.push_back(w);
      end
      acc &= (64'd1 << cnt) - 64'd1;
      if (last) begin
        // flush leftovers left-aligned, flag the frame's closing word
        if (cnt > 0) begin
          w.word = 16'(acc << (16 - cnt));
          w.last = 1'b0;
          words_due.push_back(w);
        end
        words_due[words_due.size() - 1].last = 1'b1;
        held_bits  = '0;
        held_count = 0;
        frames_closed++;
      end else begin
        held_bits  = acc[15:0];
        held_count = cnt;
      end
    endfunction

    function void check_word(logic [15:0] word, logic last);
      line_word_t w;
      if (words_due.size() == 0) begin
        $error("unexpected word: line_word %h last_word %b", word, last);
        errors++;
        return;
      end
      w = words_due.pop_front();
      words_checked++;
      if (word !== w.word) begin
        $error("line_word mismatch: expected %h actual %h", w.word, word);
        errors++;
      end
      if (last !== w.last) begin
        $error("last_word mismatch: expected %b actual %b", w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_four_bit_mode_i = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_byte_i = '0;
  logic       last_byte_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [15:0] line_word_o;
  logic       last_word_o;

  bit               no_idle = 1'b0;
  int unsigned      stuck_cycles = 0;
  line_word_tracker tracker = new();

  led_strip_spi_bit_expander_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_four_bit_mode_i(cfg_four_bit_mode_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .data_byte_i        (data_byte_i),
    .last_byte_i        (last_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .line_word_o        (line_word_o),
    .last_word_o        (last_word_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // receiver stalls at random, never while no_idle is set
  always @(posedge clk_i) begin
    out_stall_i <= !no_idle && ($urandom_range(99) < 38);
  end

  // note accepted items and check accepted words
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        tracker.note_byte(data_byte_i, last_byte_i);
      end
      if (out_valid_o && !out_stall_i) begin
        tracker.check_word(line_word_o, last_word_o);
      end
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles + 1 >= StuckLimit) begin
        $display("timeout: no handshake for %0d cycles", StuckLimit);
        $display("FAIL");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  // present one item, with a random gap first unless no_idle is set, and hold it until accepted
  task automatic send_byte(logic [7:0] data, logic last);
    if (!no_idle) begin
      while ($urandom_range(99) < 38) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= data;
    last_byte_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // stop sending and wait for every queued word
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.words_due.size() != 0) @(posedge clk_i);
  endtask

  // mode write while idle
  task automatic write_mode(bit m);
    wait_drained();
    repeat (4) @(posedge clk_i);
    cfg_we_i            <= 1'b1;
    cfg_four_bit_mode_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_mode(m);
  endtask

  initial begin
    bit          phase_mode [6] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
    int unsigned sent;
    int unsigned frame_len;
    bit          noisy;

    tracker.set_mode(1'b0);
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, 3-bit mode: single-byte frames, even and odd frame lengths
    write_mode(1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h0F, 1'b1);
    // held bits dropped by a write of the same mode
    send_byte(8'hC3, 1'b0);
    write_mode(1'b0);
    send_byte(8'h5A, 1'b1);

    // directed, 4-bit mode
    write_mode(1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h3C, 1'b1);
    send_byte(8'h81, 1'b0);

    // random frames, one mode per phase
    sent = 0;
    for (int p = 0; p < 6; p++) begin
      write_mode(phase_mode[p]);
      no_idle = (p == 2);
      while (sent < (p + 1) * RandomBytes / 6) begin
        frame_len = ($urandom_range(99) < 60) ? $urandom_range(1, 4) : $urandom_range(5, 12);
        noisy     = ($urandom_range(99) < 10);
        for (int i = 0; i < frame_len; i++) begin
          send_byte(8'($urandom()),
                    noisy ? 1'($urandom()) : (i == frame_len - 1));
          sent++;
        end
        if ($urandom_range(99) < 5) wait_drained();
      end
      // sometimes leave a frame open so the mode write must drop held bits
      if ($urandom_range(99) < 50) begin
        send_byte(8'($urandom()), 1'b0);
        sent++;
      end
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (tracker.words_due.size() != 0) begin
      $error("%0d expected words never arrived", tracker.words_due.size());
      tracker.errors++;
    end

    $display("sent %0d bytes in %0d closed frames over both line-bit modes",
             tracker.bytes_seen, tracker.frames_closed);
    $display("checked %0d SPI words, %0d mismatches", tracker.words_checked,
             tracker.errors);
    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/lsbe_pkg.sv
rtl/lsbe_in_reg.sv
rtl/lsbe_packer.sv
rtl/lsbe_out_buf.sv
rtl/led_strip_spi_bit_expander_unit.sv
verif/led_strip_spi_bit_expander_unit_tb.sv
